// ===== sv/get_pkg.sv =====
package get_pkg;

  localparam int MAX_TEXT_BYTES_DEF = 65536;
  localparam int QDEPTH = 4;
  localparam int TOKS_PER_ITEM = 3;

  typedef enum logic [3:0] {
    M_IDLE, M_SKIP, M_SLASH, M_DASH, M_STRING, M_REGEX, M_PERCENT, M_NUMBER, M_TERM, M_RULE
  } mode_t;

  typedef enum logic [4:0] {
    K_NEWLINE = 5'd0, K_PIPE = 5'd1, K_COLON = 5'd2, K_QUESTION = 5'd3, K_STAR = 5'd4,
    K_PLUS = 5'd5, K_LPAREN = 5'd6, K_RPAREN = 5'd7, K_DOT = 5'd8, K_TILDE = 5'd9,
    K_ARROW = 5'd10, K_STRING = 5'd11, K_REGEX = 5'd12, K_IGNORE = 5'd13, K_NUMBER = 5'd14,
    K_TERM = 5'd15, K_RULE = 5'd16, K_ERROR = 5'd17, K_END = 5'd18
  } kind_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start_offset;
    logic [15:0] tok_length;
    logic [15:0] line_no;
    logic [15:0] content_offset;
    logic [15:0] content_length;
  } tok_t;

  typedef struct packed {
    tok_t [TOKS_PER_ITEM-1:0] tok;
    logic [1:0]               n;
  } bundle_t;

  // Queue handshake between the lexer, the queue and the serializer
  typedef struct packed {
    logic    valid;
    bundle_t data;
  } qport_t;

  // Letters of the ignore directive, by match position
  function automatic logic [7:0] ign_char(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0: r = "%";
      3'd1: r = "i";
      3'd2: r = "g";
      3'd3: r = "n";
      3'd4: r = "o";
      3'd5: r = "r";
      3'd6: r = "e";
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] cap16(input logic [16:0] v);
    return v[16] ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic [16:0] sub_sat(input logic [16:0] a, input logic [16:0] b);
    return (a > b) ? (a - b) : 17'd0;
  endfunction

  function automatic tok_t mk_tok(input kind_t k, input logic [16:0] st, input logic [16:0] ln,
                                  input logic [15:0] line, input logic [16:0] cst,
                                  input logic [16:0] cln);
    tok_t t;
    t.kind = k;
    t.start_offset = cap16(st);
    t.tok_length = cap16(ln);
    t.line_no = line;
    t.content_offset = cap16(cst);
    t.content_length = cap16(cln);
    return t;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= "A") && (c <= "Z");
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= "a") && (c <= "z");
  endfunction

endpackage

// ===== sv/get_front.sv =====
module get_front #(
  parameter int MAX_TEXT_BYTES = get_pkg::MAX_TEXT_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_acc,
  input  logic [7:0]      ch,
  output get_pkg::qport_t push
);

  localparam int CAP_INT = ((MAX_TEXT_BYTES - 1) < 65535) ? (MAX_TEXT_BYTES - 1) : 65535;
  localparam logic [15:0] OFFSET_CAP = CAP_INT[15:0];

  get_pkg::mode_t md_r, md_nxt;
  logic [15:0] line_r, line_nxt;
  logic [15:0] off_r, off_nxt;
  logic [15:0] ts_r, ts_nxt;
  logic [2:0]  imi_r, imi_nxt;
  logic        bf_r, bf_nxt, ef_r, ef_nxt, qc_r, qc_nxt, np_r, np_nxt;

  get_pkg::tok_t [get_pkg::TOKS_PER_ITEM-1:0] tk;
  logic [1:0] cnt;

  get_pkg::tok_t e_tok;
  logic          e_v;
  logic          again, done;
  logic [16:0]   off17, ts17, cst17;
  get_pkg::kind_t pk;
  logic          pk_v;

  // Lex one byte: up to four passes over the mode, each adding at most one token
  always_comb begin
    md_nxt = md_r; line_nxt = line_r; ts_nxt = ts_r; imi_nxt = imi_r;
    bf_nxt = bf_r; ef_nxt = ef_r; qc_nxt = qc_r; np_nxt = np_r;
    off_nxt = off_r;
    tk = '0;
    cnt = 2'd0;
    e_tok = '0; e_v = 1'b0; again = 1'b0; done = 1'b0;
    off17 = {1'b0, off_r};
    ts17 = '0; cst17 = '0;
    pk = get_pkg::K_ERROR; pk_v = 1'b0;
    if (ch == 8'd0) begin
      ts17 = {1'b0, ts_r};
      cst17 = ts17 + 17'd1;
      // Flush the open token, then mark the end
      case (md_r)
        get_pkg::M_SLASH: begin
          if (np_r) begin
            tk[cnt] = get_pkg::mk_tok(get_pkg::K_NEWLINE, get_pkg::sub_sat(ts17, 17'd1),
                                      17'd1, line_r, '0, '0);
            cnt = cnt + 2'd1;
          end
          tk[cnt] = get_pkg::mk_tok(get_pkg::K_REGEX, ts17, get_pkg::sub_sat(off17, ts17),
                                    line_r, cst17, get_pkg::sub_sat(off17, cst17));
          cnt = cnt + 2'd1;
        end
        get_pkg::M_DASH: begin
          tk[cnt] = get_pkg::mk_tok(get_pkg::K_ERROR, ts17, 17'd1, line_r, '0, '0);
          cnt = cnt + 2'd1;
        end
        get_pkg::M_STRING, get_pkg::M_REGEX: begin
          tk[cnt] = get_pkg::mk_tok((md_r == get_pkg::M_STRING) ? get_pkg::K_STRING
                                    : get_pkg::K_REGEX, ts17, get_pkg::sub_sat(off17, ts17),
                                    line_r, cst17, get_pkg::sub_sat(off17, cst17));
          cnt = cnt + 2'd1;
        end
        get_pkg::M_PERCENT: begin
          if (imi_r == 3'd7) begin
            tk[cnt] = get_pkg::mk_tok(get_pkg::K_IGNORE, ts17, 17'd7, line_r, '0, '0);
            cnt = cnt + 2'd1;
          end
        end
        get_pkg::M_NUMBER: begin
          tk[cnt] = get_pkg::mk_tok(get_pkg::K_NUMBER, ts17, get_pkg::sub_sat(off17, ts17),
                                    line_r, '0, '0);
          cnt = cnt + 2'd1;
        end
        get_pkg::M_TERM, get_pkg::M_RULE: begin
          tk[cnt] = get_pkg::mk_tok((md_r == get_pkg::M_TERM) ? get_pkg::K_TERM
                                    : get_pkg::K_RULE, ts17, get_pkg::sub_sat(off17, ts17),
                                    line_r, ts17, get_pkg::sub_sat(off17, ts17));
          cnt = cnt + 2'd1;
        end
        default: ;
      endcase
      tk[cnt] = get_pkg::mk_tok(get_pkg::K_END, off17, '0, line_r, '0, '0);
      cnt = cnt + 2'd1;
      // Return to the reset state
      md_nxt = get_pkg::M_IDLE; line_nxt = 16'd1; off_nxt = '0; ts_nxt = '0;
      imi_nxt = '0; bf_nxt = 1'b0; ef_nxt = 1'b0; qc_nxt = 1'b0; np_nxt = 1'b0;
    end else begin
      for (int g = 0; g < 4; g++) begin
        if (!done) begin
          again = 1'b0;
          e_v = 1'b0;
          ts17 = {1'b0, ts_nxt};
          cst17 = ts17 + 17'd1;
          case (md_nxt)
            get_pkg::M_IDLE: begin
              if (ch == " " || ch == 8'h09 || ch == 8'h0D) begin
              end else if (ch == 8'h0A) begin
                if (line_nxt != 16'hFFFF) line_nxt = line_nxt + 16'd1;
                np_nxt = 1'b1;
              end else if (ch == "#") begin
                md_nxt = get_pkg::M_SKIP;
              end else if (ch == "/") begin
                md_nxt = get_pkg::M_SLASH;
                ts_nxt = off_r;
              end else if (np_nxt && ch != "|") begin
                e_v = 1'b1;
                e_tok = get_pkg::mk_tok(get_pkg::K_NEWLINE, get_pkg::sub_sat(off17, 17'd1),
                                        17'd1, line_nxt, '0, '0);
                np_nxt = 1'b0;
                again = 1'b1;
              end else begin
                np_nxt = 1'b0;
                ts_nxt = off_r;
                pk_v = 1'b1;
                case (ch)
                  "|": pk = get_pkg::K_PIPE;
                  ":": pk = get_pkg::K_COLON;
                  "?": pk = get_pkg::K_QUESTION;
                  "*": pk = get_pkg::K_STAR;
                  "+": pk = get_pkg::K_PLUS;
                  "(": pk = get_pkg::K_LPAREN;
                  ")": pk = get_pkg::K_RPAREN;
                  ".": pk = get_pkg::K_DOT;
                  "~": pk = get_pkg::K_TILDE;
                  default: pk_v = 1'b0;
                endcase
                if (pk_v) begin
                  e_v = 1'b1;
                  e_tok = get_pkg::mk_tok(pk, off17, 17'd1, line_nxt, '0, '0);
                end else if (ch == "-") begin
                  md_nxt = get_pkg::M_DASH;
                end else if (ch == 8'h22 || ch == 8'h27) begin
                  md_nxt = get_pkg::M_STRING;
                  qc_nxt = (ch == 8'h27);
                  ef_nxt = 1'b0;
                end else if (ch == "%") begin
                  md_nxt = get_pkg::M_PERCENT;
                  imi_nxt = 3'd1;
                end else if (get_pkg::is_digit(ch)) begin
                  md_nxt = get_pkg::M_NUMBER;
                end else if (get_pkg::is_upper(ch)) begin
                  md_nxt = get_pkg::M_TERM;
                end else if (get_pkg::is_lower(ch) || ch == "_") begin
                  md_nxt = get_pkg::M_RULE;
                end else begin
                  e_v = 1'b1;
                  e_tok = get_pkg::mk_tok(get_pkg::K_ERROR, off17, 17'd1, line_nxt, '0, '0);
                end
              end
            end
            get_pkg::M_SKIP: begin
              if (ch == 8'h0A) begin
                md_nxt = get_pkg::M_IDLE;
                again = 1'b1;
              end
            end
            get_pkg::M_SLASH: begin
              if (ch == "/") begin
                md_nxt = get_pkg::M_SKIP;
              end else begin
                if (np_nxt) begin
                  e_v = 1'b1;
                  e_tok = get_pkg::mk_tok(get_pkg::K_NEWLINE, get_pkg::sub_sat(ts17, 17'd1),
                                          17'd1, line_nxt, '0, '0);
                  np_nxt = 1'b0;
                end
                md_nxt = get_pkg::M_REGEX;
                bf_nxt = 1'b0;
                ef_nxt = 1'b0;
                again = 1'b1;
              end
            end
            get_pkg::M_DASH: begin
              md_nxt = get_pkg::M_IDLE;
              e_v = 1'b1;
              if (ch == ">") begin
                e_tok = get_pkg::mk_tok(get_pkg::K_ARROW, ts17, 17'd2, line_nxt, '0, '0);
              end else begin
                e_tok = get_pkg::mk_tok(get_pkg::K_ERROR, ts17, 17'd1, line_nxt, '0, '0);
                again = 1'b1;
              end
            end
            get_pkg::M_STRING, get_pkg::M_REGEX: begin
              if (ef_nxt) begin
                ef_nxt = 1'b0;
              end else if (ch == 8'h5C) begin
                ef_nxt = 1'b1;
              end else if (ch == 8'h0A) begin
                e_v = 1'b1;
                e_tok = get_pkg::mk_tok((md_nxt == get_pkg::M_STRING) ? get_pkg::K_STRING
                                        : get_pkg::K_REGEX, ts17,
                                        get_pkg::sub_sat(off17, ts17), line_nxt, cst17,
                                        get_pkg::sub_sat(off17, cst17));
                md_nxt = get_pkg::M_IDLE;
                again = 1'b1;
              end else if (md_nxt == get_pkg::M_STRING) begin
                if (ch == (qc_nxt ? 8'h27 : 8'h22)) begin
                  e_v = 1'b1;
                  e_tok = get_pkg::mk_tok(get_pkg::K_STRING, ts17,
                                          get_pkg::sub_sat(off17 + 17'd1, ts17), line_nxt,
                                          cst17, get_pkg::sub_sat(off17, cst17));
                  md_nxt = get_pkg::M_IDLE;
                end
              end else if (ch == "[") begin
                bf_nxt = 1'b1;
              end else if (ch == "]") begin
                bf_nxt = 1'b0;
              end else if (ch == "/" && !bf_nxt) begin
                e_v = 1'b1;
                e_tok = get_pkg::mk_tok(get_pkg::K_REGEX, ts17,
                                        get_pkg::sub_sat(off17 + 17'd1, ts17), line_nxt,
                                        cst17, get_pkg::sub_sat(off17, cst17));
                md_nxt = get_pkg::M_IDLE;
              end
            end
            get_pkg::M_PERCENT: begin
              if (imi_nxt != 3'd7) begin
                if (ch == get_pkg::ign_char(imi_nxt)) begin
                  imi_nxt = imi_nxt + 3'd1;
                end else begin
                  md_nxt = get_pkg::M_SKIP;
                  again = 1'b1;
                end
              end else if (get_pkg::is_digit(ch) || get_pkg::is_upper(ch)
                           || get_pkg::is_lower(ch)) begin
                md_nxt = get_pkg::M_SKIP;
              end else begin
                e_v = 1'b1;
                e_tok = get_pkg::mk_tok(get_pkg::K_IGNORE, ts17, 17'd7, line_nxt, '0, '0);
                md_nxt = get_pkg::M_IDLE;
                again = 1'b1;
              end
            end
            get_pkg::M_NUMBER: begin
              if (!get_pkg::is_digit(ch)) begin
                e_v = 1'b1;
                e_tok = get_pkg::mk_tok(get_pkg::K_NUMBER, ts17, get_pkg::sub_sat(off17, ts17),
                                        line_nxt, '0, '0);
                md_nxt = get_pkg::M_IDLE;
                again = 1'b1;
              end
            end
            get_pkg::M_TERM, get_pkg::M_RULE: begin
              if (!(get_pkg::is_digit(ch) || ch == "_" ||
                    ((md_nxt == get_pkg::M_TERM) ? get_pkg::is_upper(ch)
                                                 : get_pkg::is_lower(ch)))) begin
                e_v = 1'b1;
                e_tok = get_pkg::mk_tok((md_nxt == get_pkg::M_TERM) ? get_pkg::K_TERM
                                        : get_pkg::K_RULE, ts17,
                                        get_pkg::sub_sat(off17, ts17), line_nxt, ts17,
                                        get_pkg::sub_sat(off17, ts17));
                md_nxt = get_pkg::M_IDLE;
                again = 1'b1;
              end
            end
            default: begin
              md_nxt = get_pkg::M_IDLE;
              again = 1'b1;
            end
          endcase
          // Append this pass's token, dropping any beyond the third
          if (e_v && cnt != 2'd3) begin
            tk[cnt] = e_tok;
            cnt = cnt + 2'd1;
          end
          if (!again) done = 1'b1;
        end
      end
      if (off_r < OFFSET_CAP) off_nxt = off_r + 16'd1;
    end
  end

  assign push.valid = in_acc && (cnt != 2'd0);
  assign push.data.tok = tk;
  assign push.data.n = cnt;

  // Advance the lexer state on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      md_r <= get_pkg::M_IDLE; line_r <= 16'd1; off_r <= '0; ts_r <= '0; imi_r <= '0;
      bf_r <= 1'b0; ef_r <= 1'b0; qc_r <= 1'b0; np_r <= 1'b0;
    end else if (in_acc) begin
      md_r <= md_nxt; line_r <= line_nxt; off_r <= off_nxt; ts_r <= ts_nxt; imi_r <= imi_nxt;
      bf_r <= bf_nxt; ef_r <= ef_nxt; qc_r <= qc_nxt; np_r <= np_nxt;
    end
  end

endmodule

// ===== sv/get_queue.sv =====
module get_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  get_pkg::qport_t push,
  input  logic            pop,
  output logic            full,
  output get_pkg::qport_t head
);

  localparam int AW = $clog2(get_pkg::QDEPTH);

  get_pkg::bundle_t mem_r [get_pkg::QDEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r, cnt_nxt;

  assign full = (cnt_r == (AW+1)'(get_pkg::QDEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.data = mem_r[rp_r];

  // Track occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (push.valid && !pop) cnt_nxt = cnt_r + (AW+1)'(1);
    else if (!push.valid && pop) cnt_nxt = cnt_r - (AW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push.valid) wp_r <= wp_r + AW'(1);
      if (pop) rp_r <= rp_r + AW'(1);
      cnt_r <= cnt_nxt;
    end
  end

  // Store bundles
  always_ff @(posedge clk) begin
    if (push.valid) mem_r[wp_r] <= push.data;
  end

endmodule

// ===== sv/get_back.sv =====
module get_back (
  input  logic            clk,
  input  logic            rst_n,
  input  get_pkg::qport_t head,
  output logic            pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [87:0]     out_tdata,
  output logic            out_tlast
);

  logic [1:0] idx_r;
  get_pkg::tok_t t;

  assign t = head.data.tok[idx_r];
  assign out_tvalid = head.valid;
  assign out_tlast = (idx_r == head.data.n - 2'd1);
  assign out_tdata = {3'd0, t.content_length, t.content_offset, t.line_no, t.tok_length,
                      t.start_offset, t.kind};
  assign pop = out_tvalid && out_tready && out_tlast;

  // Step through the tokens of the head bundle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (out_tvalid && out_tready) begin
      idx_r <= out_tlast ? 2'd0 : idx_r + 2'd1;
    end
  end

endmodule

// ===== sv/grammar_ebnf_tokenizer_unit.sv =====
// Grammar text lexer.
// in_*: one text byte per item in in_tdata; byte 0 ends the text, flushes the
//   open token, adds an end token and returns the lexer to its reset state.
// out_*: one token per item; out_tlast marks the final token caused by a byte.
// The lexer classifies a byte in the cycle it is accepted and writes its
// tokens (up to three) as one entry into a four-entry queue; the emitter
// drains the queue one token per cycle while out_tready is high.
// The queue registers a byte's tokens; they reach out_* behind earlier entries.
// Throughput: one byte per cycle while bytes give at most one token each and
//   out_tready stays high; the emitter sends one token per item, so bursts of
//   multi-token bytes are absorbed by the queue and then paced by the emitter.
// Stall: when out_tready is low the queue fills and in_tready drops once all
//   four entries hold tokens; nothing is lost.
// Reset (rst_n low, synchronous): queue empty, line 1, offset 0, idle mode.
module grammar_ebnf_tokenizer_unit #(
  parameter int MAX_TEXT_BYTES = get_pkg::MAX_TEXT_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // kind, start_offset, tok_length, line_no,
                                  // content_offset, content_length, zero pad
  output logic        out_tlast
);

  get_pkg::qport_t push, head;
  logic full, pop, in_acc;

  assign in_tready = !full;
  assign in_acc = in_tvalid && in_tready;

  get_front #(.MAX_TEXT_BYTES(MAX_TEXT_BYTES)) u_front (
    .clk(clk), .rst_n(rst_n), .in_acc(in_acc), .ch(in_tdata), .push(push)
  );

  get_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .pop(pop), .full(full), .head(head)
  );

  get_back u_back (
    .clk(clk), .rst_n(rst_n), .head(head), .pop(pop), .out_tvalid(out_tvalid),
    .out_tready(out_tready), .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  // A bundle with more tokens keeps the output valid
  a_bundle_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("token bundle cut short");

  // The end token is always the final token of its byte
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[4:0] == get_pkg::K_END |-> out_tlast)
    else $error("end token not last");

  // An end-of-text byte always yields output next cycle
  a_end_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tdata == 8'd0 |=> out_tvalid)
    else $error("no token after end of text");

endmodule

// ===== test/tb_grammar_ebnf_tokenizer_unit.sv =====
`timescale 1ns / 100ps

module tb_grammar_ebnf_tokenizer_unit;

  typedef struct {
    get_pkg::kind_t kind;
    logic [15:0]    start_offset;
    logic [15:0]    tok_length;
    logic [15:0]    line_no;
    logic [15:0]    content_offset;
    logic [15:0]    content_length;
    logic           last;
  } token_rec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;
  logic        out_tlast;

  grammar_ebnf_tokenizer_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Text bytes waiting to be sent, and tokens the lexer should produce
  logic [7:0]  text_bytes[$];
  token_rec_t  expected_tokens[$];
  int          mismatches = 0;
  int          send_idle = 0;
  int          take_stall = 0;
  bit          calm = 1'b0;

  // Shadow lexer state
  get_pkg::mode_t lx_mode;
  int          lx_line;
  int          lx_off;
  int          lx_start;
  int          lx_ign;
  bit          lx_class;
  bit          lx_esc;
  bit          lx_single;
  bit          lx_nl;
  int          step_count;

  localparam string IGNORE_WORD = "%ignore";
  localparam int    OFF_CAP = 65535;

  function automatic int sat_sub(int a, int b);
    return (a > b) ? a - b : 0;
  endfunction

  function automatic logic [15:0] clamp16(int v);
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic bit digit_ch(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit upper_ch(logic [7:0] c);
    return c >= "A" && c <= "Z";
  endfunction

  function automatic bit lower_ch(logic [7:0] c);
    return c >= "a" && c <= "z";
  endfunction

  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic lexer_reset();
    lx_mode = get_pkg::M_IDLE;
    lx_line = 1;
    lx_off = 0;
    lx_start = 0;
    lx_ign = 0;
    lx_class = 0;
    lx_esc = 0;
    lx_single = 0;
    lx_nl = 0;
  endtask

  task automatic add_token(get_pkg::kind_t k, int st, int ln, int cst, int cln);
    token_rec_t t;
    if (step_count >= 3) return;
    t.kind = k;
    t.start_offset = clamp16(st);
    t.tok_length = clamp16(ln);
    t.line_no = lx_line[15:0];
    t.content_offset = clamp16(cst);
    t.content_length = clamp16(cln);
    t.last = 1'b0;
    expected_tokens.push_back(t);
    step_count++;
  endtask

  task automatic add_newline(int st);
    add_token(get_pkg::K_NEWLINE, st, 1, 0, 0);
    lx_nl = 0;
  endtask

  // Close a string or regex; stop is just past the token, cstop past content
  task automatic close_quoted(get_pkg::kind_t k, int stop, int cstop);
    add_token(k, lx_start, sat_sub(stop, lx_start), lx_start + 1,
              sat_sub(cstop, lx_start + 1));
    lx_mode = get_pkg::M_IDLE;
  endtask

  task automatic close_word(get_pkg::kind_t k, int off);
    int len;
    len = sat_sub(off, lx_start);
    if (k == get_pkg::K_NUMBER) add_token(k, lx_start, len, 0, 0);
    else add_token(k, lx_start, len, lx_start, len);
    lx_mode = get_pkg::M_IDLE;
  endtask

  task automatic open_token(logic [7:0] c, int off);
    lx_start = off;
    case (c)
      "|": add_token(get_pkg::K_PIPE, off, 1, 0, 0);
      ":": add_token(get_pkg::K_COLON, off, 1, 0, 0);
      "?": add_token(get_pkg::K_QUESTION, off, 1, 0, 0);
      "*": add_token(get_pkg::K_STAR, off, 1, 0, 0);
      "+": add_token(get_pkg::K_PLUS, off, 1, 0, 0);
      "(": add_token(get_pkg::K_LPAREN, off, 1, 0, 0);
      ")": add_token(get_pkg::K_RPAREN, off, 1, 0, 0);
      ".": add_token(get_pkg::K_DOT, off, 1, 0, 0);
      "~": add_token(get_pkg::K_TILDE, off, 1, 0, 0);
      "-": lx_mode = get_pkg::M_DASH;
      "\"", "'": begin
        lx_mode = get_pkg::M_STRING;
        lx_single = (c == "'");
        lx_esc = 0;
      end
      "%": begin
        lx_mode = get_pkg::M_PERCENT;
        lx_ign = 1;
      end
      default: begin
        if (digit_ch(c)) lx_mode = get_pkg::M_NUMBER;
        else if (upper_ch(c)) lx_mode = get_pkg::M_TERM;
        else if (lower_ch(c) || c == "_") lx_mode = get_pkg::M_RULE;
        else add_token(get_pkg::K_ERROR, off, 1, 0, 0);
      end
    endcase
  endtask

  // Lex one non-zero byte; a byte that ends a token is lexed again
  task automatic lex_text_byte(logic [7:0] c);
    int off;
    bit again;
    off = lx_off;
    for (int pass = 0; pass < 4; pass++) begin
      again = 0;
      case (lx_mode)
        get_pkg::M_IDLE: begin
          if (c == " " || c == "\t" || c == "\r") begin
          end else if (c == "\n") begin
            if (lx_line < 65535) lx_line++;
            lx_nl = 1;
          end else if (c == "#") begin
            lx_mode = get_pkg::M_SKIP;
          end else if (c == "/") begin
            lx_mode = get_pkg::M_SLASH;
            lx_start = off;
          end else if (lx_nl && c != "|") begin
            add_newline(sat_sub(off, 1));
            again = 1;
          end else begin
            lx_nl = 0;
            open_token(c, off);
          end
        end
        get_pkg::M_SKIP: if (c == "\n") begin
          lx_mode = get_pkg::M_IDLE;
          again = 1;
        end
        get_pkg::M_SLASH: begin
          if (c == "/") lx_mode = get_pkg::M_SKIP;
          else begin
            if (lx_nl) add_newline(sat_sub(lx_start, 1));
            lx_mode = get_pkg::M_REGEX;
            lx_class = 0;
            lx_esc = 0;
            again = 1;
          end
        end
        get_pkg::M_DASH: begin
          lx_mode = get_pkg::M_IDLE;
          if (c == ">") add_token(get_pkg::K_ARROW, lx_start, 2, 0, 0);
          else begin
            add_token(get_pkg::K_ERROR, lx_start, 1, 0, 0);
            again = 1;
          end
        end
        get_pkg::M_STRING: begin
          if (lx_esc) lx_esc = 0;
          else if (c == "\\") lx_esc = 1;
          else if (c == (lx_single ? "'" : "\""))
            close_quoted(get_pkg::K_STRING, off + 1, off);
          else if (c == "\n") begin
            close_quoted(get_pkg::K_STRING, off, off);
            again = 1;
          end
        end
        get_pkg::M_REGEX: begin
          if (lx_esc) lx_esc = 0;
          else if (c == "\\") lx_esc = 1;
          else if (c == "\n") begin
            close_quoted(get_pkg::K_REGEX, off, off);
            again = 1;
          end else if (c == "[") lx_class = 1;
          else if (c == "]") lx_class = 0;
          else if (c == "/" && !lx_class) close_quoted(get_pkg::K_REGEX, off + 1, off);
        end
        get_pkg::M_PERCENT: begin
          if (lx_ign < 7) begin
            if (c == IGNORE_WORD[lx_ign]) lx_ign++;
            else begin
              lx_mode = get_pkg::M_SKIP;
              again = 1;
            end
          end else if (digit_ch(c) || upper_ch(c) || lower_ch(c)) begin
            lx_mode = get_pkg::M_SKIP;
          end else begin
            add_token(get_pkg::K_IGNORE, lx_start, 7, 0, 0);
            lx_mode = get_pkg::M_IDLE;
            again = 1;
          end
        end
        get_pkg::M_NUMBER: if (!digit_ch(c)) begin
          close_word(get_pkg::K_NUMBER, off);
          again = 1;
        end
        get_pkg::M_TERM: if (!(upper_ch(c) || digit_ch(c) || c == "_")) begin
          close_word(get_pkg::K_TERM, off);
          again = 1;
        end
        get_pkg::M_RULE: if (!(lower_ch(c) || digit_ch(c) || c == "_")) begin
          close_word(get_pkg::K_RULE, off);
          again = 1;
        end
        default: begin
          lx_mode = get_pkg::M_IDLE;
          again = 1;
        end
      endcase
      if (!again) break;
    end
  endtask

  // Flush the open token at byte 0 and add the end token
  task automatic close_text();
    int off;
    off = lx_off;
    case (lx_mode)
      get_pkg::M_SLASH: begin
        if (lx_nl) add_newline(sat_sub(lx_start, 1));
        close_quoted(get_pkg::K_REGEX, off, off);
      end
      get_pkg::M_DASH: add_token(get_pkg::K_ERROR, lx_start, 1, 0, 0);
      get_pkg::M_STRING: close_quoted(get_pkg::K_STRING, off, off);
      get_pkg::M_REGEX: close_quoted(get_pkg::K_REGEX, off, off);
      get_pkg::M_PERCENT: if (lx_ign >= 7) add_token(get_pkg::K_IGNORE, lx_start, 7, 0, 0);
      get_pkg::M_NUMBER: close_word(get_pkg::K_NUMBER, off);
      get_pkg::M_TERM: close_word(get_pkg::K_TERM, off);
      get_pkg::M_RULE: close_word(get_pkg::K_RULE, off);
      default: ;
    endcase
    add_token(get_pkg::K_END, off, 0, 0, 0);
  endtask

  task automatic predict_byte(logic [7:0] c);
    step_count = 0;
    if (c == 8'd0) begin
      close_text();
      lexer_reset();
    end else begin
      lex_text_byte(c);
      if (lx_off < OFF_CAP) lx_off++;
    end
    if (step_count > 0) expected_tokens[$].last = 1'b1;
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("%0t: token %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  task automatic check_token(logic [87:0] d, logic lst);
    token_rec_t w;
    if (expected_tokens.size() == 0) begin
      report_mismatch("unexpected, kind", d[4:0], 0);
      return;
    end
    w = expected_tokens.pop_front();
    if (d[4:0] != w.kind) report_mismatch("kind", d[4:0], w.kind);
    if (d[20:5] != w.start_offset) report_mismatch("start", d[20:5], w.start_offset);
    if (d[36:21] != w.tok_length) report_mismatch("length", d[36:21], w.tok_length);
    if (d[52:37] != w.line_no) report_mismatch("line", d[52:37], w.line_no);
    if (d[68:53] != w.content_offset)
      report_mismatch("content offset", d[68:53], w.content_offset);
    if (d[84:69] != w.content_length)
      report_mismatch("content length", d[84:69], w.content_length);
    if (lst != w.last) report_mismatch("last", lst, w.last);
  endtask

  // Feed bytes from the pending text, with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (send_idle > 0) begin
        send_idle--;
        in_tvalid <= 1'b0;
      end else if (text_bytes.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= text_bytes.pop_front();
        send_idle = next_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Stall the token side at random; toggle calm stretches
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) calm = !calm;
    if (take_stall > 0) begin
      take_stall--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 5) == 0) take_stall = next_gap();
    end
  end

  // Check tokens, then predict from accepted bytes
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) check_token(out_tdata, out_tlast);
      if (in_tvalid && in_tready) predict_byte(in_tdata);
    end
  end

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) text_bytes.push_back(s[i]);
  endtask

  function automatic string rand_word(int first_lo, int first_hi, bit upper);
    string s;
    int n;
    s = "";
    n = $urandom_range(1, 6);
    s = {s, string'(byte'($urandom_range(first_lo, first_hi)))};
    for (int i = 1; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: s = {s, "_"};
        1: s = {s, string'(byte'($urandom_range("0", "9")))};
        default: s = {s, string'(byte'(upper ? $urandom_range("A", "Z")
                                              : $urandom_range("a", "z")))};
      endcase
    end
    return s;
  endfunction

  // One random grammar fragment, mostly well formed
  task automatic push_fragment();
    case ($urandom_range(0, 23))
      0, 1: push_text(rand_word("a", "z", 0));
      2, 3: push_text(rand_word("A", "Z", 1));
      4: push_text(rand_word("0", "9", 0));
      5: push_text({"\"", rand_word("a", "z", 0), "\\\"", rand_word("A", "Z", 1), "\""});
      6: push_text({"'", rand_word("a", "z", 0), "\\\n'"});
      7: push_text({"/[", rand_word("a", "z", 0), "/]+\\/x/"});
      8: push_text({"/", rand_word("a", "z", 0)});
      9: push_text("->");
      10: push_text("-");
      11: push_text("%ignore ");
      12: push_text({"%ign", rand_word("a", "z", 0), "\n"});
      13: push_text("# note\n");
      14: push_text("// note\n");
      15: push_text("\n  | ");
      16: push_text("\n\n \t\r");
      17: push_text(": ");
      18: push_text("?*+().~");
      19, 20: push_text(" ");
      21: text_bytes.push_back(8'($urandom_range(1, 255)));
      22: push_text("\"open\n");
      default: text_bytes.push_back(8'd0);
    endcase
  endtask

  initial begin
    int start_len;
    lexer_reset();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed text: every token kind and each special case
    push_text("start: a_1 | B2 \"s\\\"q\" 'x'?*+().~ -> - 42 /[/]\\/z/ ");
    push_text("%ignore WS\n# c\n// c\n\n  |x\n\ny @ %foo\n\"u\n/r");
    text_bytes.push_back(8'd0);
    push_text("ab");
    text_bytes.push_back(8'hFF);
    text_bytes.push_back(8'h80);
    text_bytes.push_back(8'h7F);
    push_text("\n");
    text_bytes.push_back(8'd0);
    push_text("%ignore");
    text_bytes.push_back(8'd0);
    push_text("\n/");
    text_bytes.push_back(8'd0);

    // Random grammar text, ended now and then
    start_len = text_bytes.size();
    while (text_bytes.size() - start_len < 120) push_fragment();
    text_bytes.push_back(8'd0);

    // Close with a name, a number and a lone dash
    push_text("Zz 7 -");
    text_bytes.push_back(8'd0);

    while (text_bytes.size() > 0 || in_tvalid) @(posedge clk);
    while (expected_tokens.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_tokens.size() == 0)
      $display("[grammar_ebnf_tokenizer_unit] OK");
    else
      $display("[grammar_ebnf_tokenizer_unit] ERROR");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("[grammar_ebnf_tokenizer_unit] ERROR");
    $finish;
  end

endmodule
